// ===== src/txmm_pkg.sv =====
package txmm_pkg;

    // Depth of the outstanding-request queue.
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Depth of the command queue between the front and the back.
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam int TXID_W  = 16;
    localparam int STAMP_W = 64;
    localparam int ERR_W   = 32;

    localparam int S_TDATA_W = TXID_W + STAMP_W;
    localparam int M_TDATA_W = TXID_W + 2 * STAMP_W + ERR_W;

    typedef enum logic {
        OP_REQUEST  = 1'b0,
        OP_RESPONSE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_MATCHED   = 2'd0,
        KIND_UNMATCHED = 2'd1,
        KIND_QUEUED    = 2'd2,
        KIND_DROPPED   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_POP,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        op_t                  op;
        logic [TXID_W-1:0]    txid;
        logic [STAMP_W-1:0]   stamp;
    } cmd_t;

endpackage

// ===== src/txid_request_response_matcher.sv =====
// Flow: each input word is registered in the front-end command queue, and the back end
// takes it while idle. A request, or a response to an empty queue, goes straight to the
// done state; any other response first walks the entries one per cycle and then pops
// consumed entries from the head one per cycle. The result word is then registered.
// Back end: one item at a time; it takes no new command until it is back in idle.
// Reset: rst_n is asynchronous and active low; it empties both queues and clears the error count.
module txid_request_response_matcher
    import txmm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // txid[15:0], stamp[79:16]
    input  logic                 s_tuser,   // operation: 0 request, 1 response
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // match_txid[15:0], request_stamp[79:16],
                                            // response_stamp[143:80], error_total[175:144]
    output logic [1:0]           m_tuser    // kind
);

    // The front end unpacks each input word into a command and holds up to two
    // commands, so the input side keeps moving while the back end searches or
    // while a finished result waits on the output register.
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    txmm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // The back end owns the outstanding-request queue. A request is written at the tail,
    // or dropped when the queue is full. A response walks from the head one entry per cycle,
    // skipping consumed entries and stopping at a strictly later timestamp, then pops
    // consumed entries off the head before the result word is registered.
    txmm_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== src/txmm_front.sv =====
module txmm_front
    import txmm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    cmd_t                  q_data_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  push, pop;
    cmd_t                  in_cmd;

    // Unpack the incoming word and classify it by the operation flag.
    always_comb
    begin
        in_cmd.op    = s_tuser ? OP_RESPONSE : OP_REQUEST;
        in_cmd.txid  = s_tdata[TXID_W-1:0];
        in_cmd.stamp = s_tdata[TXID_W +: STAMP_W];
    end

    assign s_tready  = (cnt_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_data_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== src/txmm_engine.sv =====
module txmm_engine
    import txmm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser
);

    // Slot of the queue at a given distance from the head, wrapped to the depth.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0]  base,
                                                 input logic [FILL_W-1:0] off);
        logic [FILL_W:0] sum;
        begin
            sum = (FILL_W + 1)'(base) + (FILL_W + 1)'(off);
            if (sum >= (FILL_W + 1)'(QUEUE_DEPTH))
            begin
                sum = sum - (FILL_W + 1)'(QUEUE_DEPTH);
            end
            return sum[IDX_W-1:0];
        end
    endfunction

    eng_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  off_reg, off_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    kind_t              kind_reg, kind_next;
    logic [STAMP_W-1:0] req_ts_reg, req_ts_next;
    cmd_t               cmd_reg;
    logic [QUEUE_DEPTH-1:0] used_reg, used_next;

    logic [TXID_W-1:0]  mem_id    [QUEUE_DEPTH];
    logic [STAMP_W-1:0] mem_stamp [QUEUE_DEPTH];
    logic [TXID_W-1:0]  rd_id_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               mem_we;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [TXID_W-1:0]  out_txid_reg;
    logic [STAMP_W-1:0] out_req_ts_reg;
    logic [STAMP_W-1:0] out_resp_ts_reg;
    logic [ERR_W-1:0]   out_err_reg;
    logic               out_load;

    logic [IDX_W-1:0]   cmp_slot;
    logic               cmp_used, cmp_later, cmp_id_eq, cmp_last;
    logic               srch_match, srch_miss;
    logic               take_cmd, full, pop_head, out_free;
    logic [ERR_W-1:0]   err_inc;

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign take_cmd  = (state_reg == ST_IDLE) && cmd_valid;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign err_inc   = (err_reg == {ERR_W{1'b1}}) ? err_reg : err_reg + 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // Entry under test in the search: its data was read in the cycle before.
    assign cmp_slot   = slot_of(head_reg, off_reg);
    assign cmp_used   = used_reg[cmp_slot];
    assign cmp_later  = (rd_stamp_reg > cmd_reg.stamp);
    assign cmp_id_eq  = (rd_id_reg == cmd_reg.txid);
    assign cmp_last   = ((FILL_W + 1)'(off_reg) + 1'b1 == (FILL_W + 1)'(fill_reg));
    assign srch_match = !cmp_used && !cmp_later && cmp_id_eq;
    assign srch_miss  = !srch_match && ((!cmp_used && cmp_later) || cmp_last);
    assign pop_head   = (fill_reg != '0) && used_reg[head_reg];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_RESPONSE && fill_reg != '0)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (srch_match || srch_miss)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (!pop_head)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and control outputs.
    always_comb
    begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        off_next    = off_reg;
        err_next    = err_reg;
        kind_next   = kind_reg;
        req_ts_next = req_ts_reg;
        used_next   = used_reg;
        mem_we      = 1'b0;
        wr_addr     = slot_of(head_reg, fill_reg);
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                off_next    = '0;
                req_ts_next = '0;
                if (cmd_valid)
                begin
                    if (cmd.op == OP_REQUEST)
                    begin
                        if (full)
                        begin
                            kind_next = KIND_DROPPED;
                            err_next  = err_inc;
                        end
                        else
                        begin
                            kind_next          = KIND_QUEUED;
                            mem_we             = 1'b1;
                            used_next[wr_addr] = 1'b0;
                            fill_next          = fill_reg + 1'b1;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        kind_next = KIND_UNMATCHED;
                        err_next  = err_inc;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (srch_match)
                begin
                    kind_next           = KIND_MATCHED;
                    req_ts_next         = rd_stamp_reg;
                    used_next[cmp_slot] = 1'b1;
                end
                else if (srch_miss)
                begin
                    kind_next = KIND_UNMATCHED;
                    err_next  = err_inc;
                end
                else
                begin
                    off_next = off_reg + 1'b1;
                end
            end
            ST_POP:
            begin
                if (pop_head)
                begin
                    head_next = slot_of(head_reg, FILL_W'(1));
                    fill_next = fill_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // The read address follows the next search offset, so the entry is
    // registered by the time the search looks at it.
    assign rd_addr = slot_of(head_reg, off_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            err_reg   <= err_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        kind_reg   <= kind_next;
        req_ts_reg <= req_ts_next;
        used_reg   <= used_next;
        if (take_cmd)
        begin
            cmd_reg <= cmd;
        end
        if (out_load)
        begin
            out_kind_reg    <= kind_reg;
            out_txid_reg    <= cmd_reg.txid;
            out_req_ts_reg  <= req_ts_reg;
            out_resp_ts_reg <= (cmd_reg.op == OP_RESPONSE) ? cmd_reg.stamp : '0;
            out_err_reg     <= err_reg;
        end
    end

    // Entry store: one write port at the tail, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_id[wr_addr]    <= cmd.txid;
            mem_stamp[wr_addr] <= cmd.stamp;
        end
        rd_id_reg    <= mem_id[rd_addr];
        rd_stamp_reg <= mem_stamp[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_err_reg, out_resp_ts_reg, out_req_ts_reg, out_txid_reg};

endmodule

// ===== src/txmm_checker.sv =====
module txmm_checker
    import txmm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    logic [STAMP_W-1:0] req_ts;
    logic [STAMP_W-1:0] resp_ts;
    logic [ERR_W-1:0]   err_total;

    assign req_ts    = m_tdata[TXID_W +: STAMP_W];
    assign resp_ts   = m_tdata[TXID_W + STAMP_W +: STAMP_W];
    assign err_total = m_tdata[TXID_W + 2 * STAMP_W +: ERR_W];

    // A stalled input word holds.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input word changed while stalled");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Request results carry no timestamps.
    a_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_QUEUED || m_tuser == KIND_DROPPED)
        |-> req_ts == '0 && resp_ts == '0)
        else $error("request result carries a timestamp");

    // An unmatched response reports no request timestamp.
    a_unm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_UNMATCHED |-> req_ts == '0)
        else $error("unmatched response carries a request timestamp");

    // An error result always comes with a nonzero error count.
    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_UNMATCHED || m_tuser == KIND_DROPPED)
        |-> err_total != '0)
        else $error("error result with zero error count");

endmodule

bind txid_request_response_matcher txmm_checker u_txmm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
